/* rtl/csvt_pkg.sv */
package csvt_pkg;

	localparam int ByteW = 8;

	localparam logic [ByteW-1:0] CH_QUOTE = 8'h22;
	localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
	localparam logic [ByteW-1:0] CH_LF    = 8'h0A;

	localparam logic [ByteW-1:0] SEP_RESET = 8'd44;

	// token kinds on the result channel
	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_FIELD  = 2'd1,
		KIND_RECORD = 2'd2
	} kind_t;

	// parser flags carried from one word to the next
	typedef struct packed {
		logic in_quotes;
		logic quote_pending;
		logic cr_pending;
		logic record_started;
	} pstate_t;

	// one decoded result
	typedef struct packed {
		logic             emit;
		kind_t            kind;
		logic [ByteW-1:0] data;
	} token_t;

endpackage

/* rtl/csvt_step.sv */
module csvt_step (
	input  logic [csvt_pkg::ByteW-1:0] data_byte,
	input  logic                       end_of_input,
	input  logic [csvt_pkg::ByteW-1:0] separator,
	input  csvt_pkg::pstate_t          state,
	output csvt_pkg::pstate_t          state_next,
	output csvt_pkg::token_t           token
);

	logic unquoted;

	always_comb begin
		state_next = state;
		token      = '{emit: 1'b0, kind: csvt_pkg::KIND_BYTE, data: '0};
		unquoted   = 1'b0;

		if (end_of_input) begin
			// close a started record, then back to reset flags
			token.emit = state.record_started;
			token.kind = csvt_pkg::KIND_RECORD;
			state_next = '0;
		end else begin
			state_next.cr_pending = 1'b0;
			if (state.cr_pending && data_byte == csvt_pkg::CH_LF) begin
				// lf of a crlf pair is swallowed
			end else if (state.quote_pending) begin
				state_next.quote_pending  = 1'b0;
				state_next.record_started = 1'b1;
				if (data_byte == csvt_pkg::CH_QUOTE) begin
					token.emit = 1'b1;
					token.data = csvt_pkg::CH_QUOTE;
				end else begin
					state_next.in_quotes = 1'b0;
					unquoted             = 1'b1;
				end
			end else if (state.in_quotes) begin
				state_next.record_started = 1'b1;
				if (data_byte == csvt_pkg::CH_QUOTE) begin
					state_next.quote_pending = 1'b1;
				end else begin
					token.emit = 1'b1;
					token.data = data_byte;
				end
			end else begin
				unquoted = 1'b1;
			end

			if (unquoted) begin
				state_next.record_started = 1'b1;
				if (data_byte == csvt_pkg::CH_QUOTE) begin
					state_next.in_quotes = 1'b1;
				end else if (data_byte == separator) begin
					token.emit = 1'b1;
					token.kind = csvt_pkg::KIND_FIELD;
				end else if (data_byte == csvt_pkg::CH_CR) begin
					state_next.cr_pending     = 1'b1;
					state_next.record_started = 1'b0;
					token.emit                = 1'b1;
					token.kind                = csvt_pkg::KIND_RECORD;
				end else if (data_byte == csvt_pkg::CH_LF) begin
					state_next.record_started = 1'b0;
					token.emit                = 1'b1;
					token.kind                = csvt_pkg::KIND_RECORD;
				end else begin
					token.emit = 1'b1;
					token.data = data_byte;
				end
			end
		end
	end

endmodule

/* rtl/csv_record_tokenizer.sv */
// csv record tokenizer
// input channel: in_valid/in_ready carry one word per accept, either a stream
//   byte (data_byte) or an end marker (end_of_input high, data_byte ignored)
// output channel: out_valid/out_ready carry tokens; token_kind tells a content
//   byte (field_byte holds it), an end of field, or an end of field and record
// cfg_we/cfg_data write the separator byte; write it only while idle
// throughput: one word per cycle; the parser flags are a few bits updated by
//   a single combinational step between the input and the output register
// latency: a word accepted at edge n shows its token right after edge n+1, so
//   it can be taken at edge n+2 at the earliest; words that give no token
//   (quote, swallowed lf, empty end) vanish
// stall: when out_ready is low the output register holds, the input register
//   holds the next word, and in_ready drops only while both are full
// reset: arst_n clears the flags and both valid bits and sets the
//   separator to comma
module csv_record_tokenizer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [csvt_pkg::ByteW-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [csvt_pkg::ByteW-1:0] data_byte,
	input  logic                       end_of_input,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 token_kind,
	output logic [csvt_pkg::ByteW-1:0] field_byte
);

	// separator register
	logic [csvt_pkg::ByteW-1:0] separator_q;

	// input register
	logic                       valid_s1;
	logic [csvt_pkg::ByteW-1:0] byte_s1;
	logic                       eoi_s1;

	// output register
	logic                       valid_s2;
	csvt_pkg::kind_t            kind_s2;
	logic [csvt_pkg::ByteW-1:0] data_s2;

	// parser flags
	csvt_pkg::pstate_t state_q;
	csvt_pkg::pstate_t state_next;
	csvt_pkg::token_t  token;

	logic advance;

	// the staged word moves on when the output slot is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	csvt_step u_step (
		.data_byte    (byte_s1),
		.end_of_input (eoi_s1),
		.separator    (separator_q),
		.state        (state_q),
		.state_next   (state_next),
		.token        (token)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q <= csvt_pkg::SEP_RESET;
		end else if (cfg_we) begin
			separator_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			eoi_s1  <= end_of_input;
		end
	end

	// flags advance once per staged word, in stream order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= token.emit;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && token.emit) begin
			kind_s2 <= token.kind;
			data_s2 <= token.data;
		end
	end

	assign out_valid  = valid_s2;
	assign token_kind = kind_s2;
	assign field_byte = data_s2;

endmodule
